FILE: sv/fpl_pkg.sv
package fpl_pkg;

    // default coordinate and accumulator widths
    localparam int COORD_BITS_DEF = 16;
    localparam int ACC_BITS_DEF   = 32;

    // point index width, fixed by the result format
    localparam int IDX_BITS = 16;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_DX,
        ST_SQ_DY,
        ST_ROOT,
        ST_UPDATE
    } state_t;

endpackage

FILE: sv/farthest_point_and_path_length.sv
// Farthest point and polyline length over a stream of 2-D points.
// Slave channel: one transfer per point, x and y in signed Q11.4 in tdata,
// tlast marks the final point of a list. Master channel: one transfer per
// point with the running farthest point (index, x, y, squared norm) and the
// saturating path length in tdata, the saturation flag in tuser, and tlast
// set on the result for the final point of a list.
// Each point makes four passes through one shared squaring multiplier, then
// takes COORD_BITS + 1 steps of a bit-serial square root, an update state and
// the idle state. s_axis_tready is low from the input transfer until the
// sequencer is back in the idle state.
// The result sits in an output register, so a new point is taken while it
// waits; if the receiver stalls, the next point finishes and then holds in
// the update cycle until the output register is free.
// A synchronous reset (aresetn low) clears the running state and drops
// m_axis_tvalid. The running state also clears as the result for a final point is loaded.
module farthest_point_and_path_length #(
    parameter int COORD_BITS = fpl_pkg::COORD_BITS_DEF,
    parameter int ACC_BITS   = fpl_pkg::ACC_BITS_DEF,
    localparam int S_TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8,
    localparam int M_FIELDS_W = fpl_pkg::IDX_BITS + 4 * COORD_BITS + ACC_BITS,
    localparam int M_TDATA_W = ((M_FIELDS_W + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // point_x, point_y
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // far_index, far_x, far_y,
                                                 // far_norm_sq, path_length
    output logic                 m_axis_tuser,   // length_saturated
    output logic                 m_axis_tlast
);

    localparam int IDX_BITS = fpl_pkg::IDX_BITS;
    localparam int NORM_W   = 2 * COORD_BITS;
    localparam int OP_W     = COORD_BITS + 1;
    localparam int RW       = OP_W;
    localparam int SQ_W     = 2 * RW;
    localparam int REM_W    = RW + 2;
    localparam int ITER_W   = $clog2(RW);
    localparam int SUM_W    = ((ACC_BITS > RW) ? ACC_BITS : RW) + 1;

    fpl_pkg::state_t state_reg, state_next;

    // running state
    logic [COORD_BITS-1:0] prev_x_reg, prev_y_reg;
    logic [IDX_BITS-1:0]   count_reg;
    logic [NORM_W-1:0]     best_norm_reg;
    logic [IDX_BITS-1:0]   best_index_reg;
    logic [COORD_BITS-1:0] best_x_reg, best_y_reg;
    logic [ACC_BITS-1:0]   acc_reg;
    logic                  sat_reg;

    // working registers of the current point
    logic [COORD_BITS-1:0] cur_x_reg, cur_y_reg;
    logic                  last_reg;
    logic [OP_W-1:0]       ax_reg, ay_reg, dx_reg, dy_reg;
    logic [NORM_W-1:0]     norm_reg;
    logic [SQ_W-1:0]       rad_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [RW-1:0]         root_reg;
    logic [ITER_W-1:0]     iter_reg;

    // output register
    logic                  out_valid_reg;
    logic [M_FIELDS_W-1:0] out_data_reg;
    logic                  out_sat_reg;
    logic                  out_last_reg;

    logic                  in_xfer;
    logic                  load_out;

    // input field extraction and operand preparation
    logic [COORD_BITS-1:0] x_in, y_in;
    logic [COORD_BITS-1:0] ax_in, ay_in;
    logic [COORD_BITS:0]   dx_s, dy_s;
    logic [OP_W-1:0]       dx_in, dy_in;

    always_comb begin
        x_in  = s_axis_tdata[COORD_BITS-1:0];
        y_in  = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
        ax_in = x_in[COORD_BITS-1] ? (~x_in + 1'b1) : x_in;
        ay_in = y_in[COORD_BITS-1] ? (~y_in + 1'b1) : y_in;
        dx_s  = {x_in[COORD_BITS-1], x_in} - {prev_x_reg[COORD_BITS-1], prev_x_reg};
        dy_s  = {y_in[COORD_BITS-1], y_in} - {prev_y_reg[COORD_BITS-1], prev_y_reg};
        dx_in = dx_s[COORD_BITS] ? (~dx_s + 1'b1) : dx_s;
        dy_in = dy_s[COORD_BITS] ? (~dy_s + 1'b1) : dy_s;
    end

    // shared squaring unit
    logic [OP_W-1:0] mul_op;
    logic [SQ_W-1:0] mul_prod;

    always_comb begin
        case (state_reg)
            fpl_pkg::ST_SQ_X:  mul_op = ax_reg;
            fpl_pkg::ST_SQ_Y:  mul_op = ay_reg;
            fpl_pkg::ST_SQ_DX: mul_op = dx_reg;
            fpl_pkg::ST_SQ_DY: mul_op = dy_reg;
            default:           mul_op = '0;
        endcase
    end

    assign mul_prod = mul_op * mul_op;

    // one square root digit per cycle
    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] root_trial;
    logic [REM_W+1:0] rem_diff;
    logic             root_bit;

    always_comb begin
        rem_sh     = {rem_reg, rad_reg[SQ_W-1 -: 2]};
        root_trial = {2'b00, root_reg, 2'b01};
        rem_diff   = rem_sh - root_trial;
        root_bit   = (rem_sh >= root_trial);
    end

    // point count, segment accumulation with saturation
    logic [IDX_BITS-1:0] cnt_inc;
    logic                do_seg;
    logic [SUM_W-1:0]    acc_sum;
    logic                acc_ovf;
    logic [ACC_BITS-1:0] acc_upd;
    logic                sat_upd;

    always_comb begin
        cnt_inc = (&count_reg) ? count_reg : count_reg + 1'b1;
        do_seg  = (count_reg != '0);
        acc_sum = SUM_W'(acc_reg) + SUM_W'(root_reg);
        acc_ovf = |acc_sum[SUM_W-1:ACC_BITS];
        if (do_seg) begin
            acc_upd = acc_ovf ? '1 : acc_sum[ACC_BITS-1:0];
            sat_upd = sat_reg | acc_ovf;
        end else begin
            acc_upd = acc_reg;
            sat_upd = sat_reg;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fpl_pkg::ST_IDLE:   if (s_axis_tvalid) state_next = fpl_pkg::ST_SQ_X;
            fpl_pkg::ST_SQ_X:   state_next = fpl_pkg::ST_SQ_Y;
            fpl_pkg::ST_SQ_Y:   state_next = fpl_pkg::ST_SQ_DX;
            fpl_pkg::ST_SQ_DX:  state_next = fpl_pkg::ST_SQ_DY;
            fpl_pkg::ST_SQ_DY:  state_next = fpl_pkg::ST_ROOT;
            fpl_pkg::ST_ROOT:   if (iter_reg == '0) state_next = fpl_pkg::ST_UPDATE;
            fpl_pkg::ST_UPDATE: if (!out_valid_reg || m_axis_tready) begin
                state_next = fpl_pkg::ST_IDLE;
            end
            default:            state_next = fpl_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_axis_tready = (state_reg == fpl_pkg::ST_IDLE);
        in_xfer       = s_axis_tvalid && s_axis_tready;
        load_out      = (state_reg == fpl_pkg::ST_UPDATE) && (!out_valid_reg || m_axis_tready);
    end

    // control and running state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= fpl_pkg::ST_IDLE;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            count_reg      <= '0;
            best_norm_reg  <= '0;
            best_index_reg <= '0;
            best_x_reg     <= '0;
            best_y_reg     <= '0;
            acc_reg        <= '0;
            sat_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;

            // strict compare keeps the earliest of equal norms
            if (state_reg == fpl_pkg::ST_SQ_DX && norm_reg > best_norm_reg) begin
                best_norm_reg  <= norm_reg;
                best_index_reg <= cnt_inc;
                best_x_reg     <= cur_x_reg;
                best_y_reg     <= cur_y_reg;
            end

            if (load_out) begin
                if (last_reg) begin
                    prev_x_reg     <= '0;
                    prev_y_reg     <= '0;
                    count_reg      <= '0;
                    best_norm_reg  <= '0;
                    best_index_reg <= '0;
                    best_x_reg     <= '0;
                    best_y_reg     <= '0;
                    acc_reg        <= '0;
                    sat_reg        <= 1'b0;
                end else begin
                    prev_x_reg <= cur_x_reg;
                    prev_y_reg <= cur_y_reg;
                    count_reg  <= cnt_inc;
                    acc_reg    <= acc_upd;
                    sat_reg    <= sat_upd;
                end
            end

            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            cur_x_reg <= x_in;
            cur_y_reg <= y_in;
            last_reg  <= s_axis_tlast;
            ax_reg    <= {1'b0, ax_in};
            ay_reg    <= {1'b0, ay_in};
            dx_reg    <= dx_in;
            dy_reg    <= dy_in;
        end

        case (state_reg)
            fpl_pkg::ST_SQ_X: begin
                norm_reg <= mul_prod[NORM_W-1:0];
            end
            fpl_pkg::ST_SQ_Y: begin
                norm_reg <= norm_reg + mul_prod[NORM_W-1:0];
            end
            fpl_pkg::ST_SQ_DX: begin
                rad_reg <= mul_prod;
            end
            fpl_pkg::ST_SQ_DY: begin
                rad_reg  <= rad_reg + mul_prod;
                rem_reg  <= '0;
                root_reg <= '0;
                iter_reg <= ITER_W'(RW - 1);
            end
            fpl_pkg::ST_ROOT: begin
                rem_reg  <= root_bit ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
                root_reg <= {root_reg[RW-2:0], root_bit};
                rad_reg  <= {rad_reg[SQ_W-3:0], 2'b00};
                iter_reg <= iter_reg - 1'b1;
            end
            default: begin
            end
        endcase

        // result fields from the lowest bit up
        if (load_out) begin
            out_data_reg <= {acc_upd, best_norm_reg, best_y_reg, best_x_reg, best_index_reg};
            out_sat_reg  <= sat_upd;
            out_last_reg <= last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'(out_data_reg);
    assign m_axis_tuser  = out_sat_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

FILE: sv/fpl_checker.sv
module fpl_checker #(
    parameter int COORD_BITS = fpl_pkg::COORD_BITS_DEF,
    parameter int ACC_BITS   = fpl_pkg::ACC_BITS_DEF,
    localparam int S_TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8,
    localparam int M_FIELDS_W = fpl_pkg::IDX_BITS + 4 * COORD_BITS + ACC_BITS,
    localparam int M_TDATA_W = ((M_FIELDS_W + 7) / 8) * 8
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [S_TDATA_W-1:0] s_axis_tdata,
    input logic                 s_axis_tlast,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic                 m_axis_tuser,
    input logic                 m_axis_tlast
);

    localparam int PATH_LSB = fpl_pkg::IDX_BITS + 4 * COORD_BITS;

    // reset leaves the block empty and ready
    assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid && s_axis_tready)
        else $error("block not empty and ready after reset");

    // one point at a time: a transfer in closes the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a point is in progress");

    // no new result appears in the cycle after a point is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result appeared too soon after input transfer");

    // a saturated length sticks at the accumulator maximum
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> &m_axis_tdata[PATH_LSB+ACC_BITS-1:PATH_LSB])
        else $error("saturation flagged with length below maximum");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result changed");

endmodule

bind farthest_point_and_path_length fpl_checker #(
    .COORD_BITS(COORD_BITS),
    .ACC_BITS  (ACC_BITS)
) u_fpl_checker (.*);
